[hw/rtl/hfn_pkg.sv]
// ---------------------------------------------------------------------------
// hfn_pkg
// Shared types and constants of the height-field normal generator.
// ---------------------------------------------------------------------------
package hfn_pkg;

	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS        = 256;
	localparam int QUEUE_DEPTH     = 4;
	localparam int SLOPE_W         = 20;
	localparam int MAG_W           = 36;
	localparam int SQ_W            = 62;
	localparam int ROOT_W          = 31;
	localparam int ADDR_W          = 4;

	typedef enum logic [1:0] {
		REG_GRID_COLUMNS = 2'd0,
		REG_GRID_ROWS    = 2'd1,
		REG_CELL_SIZE_X  = 2'd2,
		REG_CELL_SIZE_Y  = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic signed [SLOPE_W-1:0] sx;
		logic signed [SLOPE_W-1:0] sy;
		logic signed [15:0]        centre;
		logic [7:0]                column;
		logic [7:0]                row;
		logic                      last;
	} slope_req_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MULX,
		B_MULY,
		B_MULC,
		B_MULZ,
		B_NORM,
		B_SQX,
		B_SQY,
		B_SQZ,
		B_ROOT,
		B_DIVS,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

[hw/rtl/heightfield_normal_generator.sv]
// ---------------------------------------------------------------------------
// heightfield_normal_generator
// 3x3 slope filter over a height raster with a unit normal per interior sample.
// ---------------------------------------------------------------------------
//  channel   handshake             payload
//  input     push / full           height
//  result    empty / pop           column row centre_height normal_x/y/z last
//  config    APB psel/penable      paddr pwdata prdata
//
// A border sample is handled in the front part only. In the back part an
// interior sample passes through 31 square-root steps and three 15-step
// divisions; the three divisions share one iterative divider. A four-entry
// request queue lets the front run ahead. A fill count marks the written part
// of the line stores, so reset needs no clearing pass.
// ---------------------------------------------------------------------------
module heightfield_normal_generator #(
	parameter int MAX_COLUMNS = hfn_pkg::MAX_COLUMNS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [hfn_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       push,
	output logic                       full,
	input  logic signed [15:0]         height,
	output logic                       empty,
	input  logic                       pop,
	output logic [7:0]                 column,
	output logic [7:0]                 row,
	output logic signed [15:0]         centre_height,
	output logic signed [15:0]         normal_x,
	output logic signed [15:0]         normal_y,
	output logic [14:0]                normal_z,
	output logic                       last
);
	import hfn_pkg::*;

	logic [8:0]  grid_columns_q;
	logic [8:0]  grid_rows_q;
	logic [15:0] cell_size_x_q;
	logic [15:0] cell_size_y_q;
	logic        wr;
	logic        restart;
	reg_index_t  idx;
	logic        q_push, q_full, q_pop, q_empty;
	slope_req_t  req_in, req_out;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_index_t'(paddr[3:2]);
	assign restart = wr && (idx == REG_GRID_COLUMNS || idx == REG_GRID_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= 9'd256;
			grid_rows_q    <= 9'd256;
			cell_size_x_q  <= 16'd256;
			cell_size_y_q  <= 16'd256;
		end else if (wr) begin
			case (idx)
				REG_GRID_COLUMNS: grid_columns_q <= pwdata[8:0];
				REG_GRID_ROWS:    grid_rows_q    <= pwdata[8:0];
				REG_CELL_SIZE_X:  cell_size_x_q  <= pwdata[15:0];
				REG_CELL_SIZE_Y:  cell_size_y_q  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GRID_COLUMNS: prdata = 32'(grid_columns_q);
			REG_GRID_ROWS:    prdata = 32'(grid_rows_q);
			REG_CELL_SIZE_X:  prdata = 32'(cell_size_x_q);
			REG_CELL_SIZE_Y:  prdata = 32'(cell_size_y_q);
			default:          prdata = 32'd0;
		endcase
	end

	hfn_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.grid_columns (grid_columns_q),
		.grid_rows    (grid_rows_q),
		.restart      (restart),
		.push         (push),
		.full         (full),
		.height       (height),
		.q_push       (q_push),
		.q_full       (q_full),
		.q_req        (req_in)
	);

	hfn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (req_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (req_out),
		.empty  (q_empty)
	);

	hfn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cell_size_x   (cell_size_x_q),
		.cell_size_y   (cell_size_y_q),
		.q_empty       (q_empty),
		.q_req         (req_out),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.column        (column),
		.row           (row),
		.centre_height (centre_height),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.normal_z      (normal_z),
		.last          (last)
	);

endmodule

[hw/rtl/hfn_front.sv]
// ---------------------------------------------------------------------------
// hfn_front
// Raster counters, line stores and 3x3 window; forms the slope request.
// ---------------------------------------------------------------------------
module hfn_front #(
	parameter int MAX_COLUMNS = hfn_pkg::MAX_COLUMNS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [8:0]          grid_columns,
	input  logic [8:0]          grid_rows,
	input  logic                restart,
	input  logic                push,
	output logic                full,
	input  logic signed [15:0]  height,
	output logic                q_push,
	input  logic                q_full,
	output hfn_pkg::slope_req_t q_req
);
	import hfn_pkg::*;

	localparam int Depth = MAX_COLUMNS + 2;
	localparam int CW    = $clog2(Depth);

	logic [CW-1:0] cc_q;
	logic [8:0]    rc_q;
	logic [CW:0]   cols_eff;
	logic [8:0]    rows_eff;
	logic          accept;
	logic          advance;
	logic          produce;

	logic [15:0]     mem_a [Depth];
	logic [15:0]     mem_b [Depth];
	logic [CW:0]     fill_q;

	logic               valid_s1;
	logic signed [15:0] h_s1;
	logic [CW-1:0]      cc_s1;
	logic [8:0]         rc_s1;
	logic               last_s1;
	logic [15:0]        rda_s1;
	logic [15:0]        rdb_s1;
	logic               va_s1;
	logic [15:0]        a_dat;
	logic [15:0]        b_dat;
	logic signed [15:0] w_q [9];
	logic signed [15:0] nw [9];
	logic signed [SLOPE_W-1:0] e [9];

	always_comb begin
		if (grid_columns < 9'd2) begin
			cols_eff = (CW+1)'(2);
		end else if (int'(grid_columns) > MAX_COLUMNS) begin
			cols_eff = (CW+1)'(MAX_COLUMNS);
		end else begin
			cols_eff = (CW+1)'(grid_columns);
		end
		if (grid_rows < 9'd2) begin
			rows_eff = 9'd2;
		end else if (int'(grid_rows) > MAX_ROWS) begin
			rows_eff = 9'(MAX_ROWS);
		end else begin
			rows_eff = grid_rows;
		end
	end

	assign produce = (rc_s1 >= 9'd2) && (cc_s1 >= CW'(2));
	assign advance = valid_s1 && (!produce || !q_full);
	assign full    = valid_s1 && !advance;
	assign accept  = push && !full;
	assign q_push  = advance && produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= '0;
			rc_q <= '0;
		end else if (restart) begin
			cc_q <= '0;
			rc_q <= '0;
		end else if (accept) begin
			if ((CW+1)'(cc_q) == cols_eff + 1'b1) begin
				cc_q <= '0;
				rc_q <= (rc_q == rows_eff + 9'd1) ? 9'd0 : rc_q + 9'd1;
			end else begin
				cc_q <= cc_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h_s1    <= height;
			cc_s1   <= cc_q;
			rc_s1   <= rc_q;
			last_s1 <= (rc_q == rows_eff + 9'd1) && ((CW+1)'(cc_q) == cols_eff + 1'b1);
			rda_s1  <= mem_a[cc_q];
			rdb_s1  <= mem_b[cc_q];
			va_s1   <= (CW+1)'(cc_q) < fill_q;
		end
		if (advance) begin
			mem_a[cc_s1] <= h_s1;
			mem_b[cc_s1] <= a_dat;
		end
	end

	assign a_dat = va_s1 ? rda_s1 : 16'd0;
	assign b_dat = va_s1 ? rdb_s1 : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < 9; i++) begin
				w_q[i] <= '0;
			end
		end else if (advance) begin
			if ((CW+1)'(cc_s1) == fill_q) begin
				fill_q <= fill_q + 1'b1;
			end
			for (int i = 0; i < 9; i++) begin
				w_q[i] <= nw[i];
			end
		end
	end

	always_comb begin
		nw[0] = w_q[1];
		nw[1] = w_q[2];
		nw[2] = b_dat;
		nw[3] = w_q[4];
		nw[4] = w_q[5];
		nw[5] = a_dat;
		nw[6] = w_q[7];
		nw[7] = w_q[8];
		nw[8] = h_s1;
		for (int i = 0; i < 9; i++) begin
			e[i] = SLOPE_W'(nw[i]);
		end
		q_req.sx     = ((e[3] - e[5]) <<< 2) + (e[0] - e[2]) + (e[8] - e[6]);
		q_req.sy     = ((e[1] - e[7]) <<< 2) + (e[0] - e[6]) + (e[2] - e[8]);
		q_req.centre = nw[4];
		q_req.column = 8'(cc_s1 - CW'(2));
		q_req.row    = 8'(rc_s1 - 9'd2);
		q_req.last   = last_s1;
	end

`ifndef SYNTH
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("request pushed into a full queue");
`endif

endmodule

[hw/rtl/hfn_queue.sv]
// ---------------------------------------------------------------------------
// hfn_queue
// Short queue of slope requests between the front and back parts.
// ---------------------------------------------------------------------------
module hfn_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hfn_pkg::slope_req_t din,
	output logic                full,
	input  logic                pop,
	output hfn_pkg::slope_req_t dout,
	output logic                empty
);
	import hfn_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	slope_req_t   buf_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   count_q;

	assign full  = count_q == (PW+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign dout  = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop && !empty) begin
				rp_q <= rp_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_count_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop on pop");
`endif

endmodule

[hw/rtl/hfn_back.sv]
// ---------------------------------------------------------------------------
// hfn_back
// Sequential normal unit: scale, normalize, square root, divide, output.
// ---------------------------------------------------------------------------
module hfn_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         cell_size_x,
	input  logic [15:0]         cell_size_y,
	input  logic                q_empty,
	input  hfn_pkg::slope_req_t q_req,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output logic [7:0]          column,
	output logic [7:0]          row,
	output logic signed [15:0]  centre_height,
	output logic signed [15:0]  normal_x,
	output logic signed [15:0]  normal_y,
	output logic [14:0]         normal_z,
	output logic                last
);
	import hfn_pkg::*;

	back_state_t state_q, state_d;

	slope_req_t          req_q;
	logic [15:0]         cx;
	logic [15:0]         cy;
	logic [MAG_W-1:0]    mx_q, my_q, mz_q;
	logic                negx_q, negy_q;
	logic signed [SLOPE_W+16:0] prod;
	logic [MAG_W-1:0]    pmag;
	logic [MAG_W-1:0]    m;
	logic [2:0]          s;
	logic [59:0]         sq;
	logic [29:0]         sq_op;
	logic [SQ_W-1:0]     q_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [ROOT_W+1:0]   rrem;
	logic [ROOT_W+1:0]   rtrial;
	logic [ROOT_W-1:0]   rt;
	logic [4:0]          cnt_q;
	logic [1:0]          ci_q;
	logic [MAG_W-1:0]    dm;
	logic [44:0]         num;
	logic [31:0]         drem_q;
	logic [31:0]         drem2;
	logic [14:0]         lo_q;
	logic [14:0]         quo_q;
	logic [14:0]         qx_q, qy_q;
	logic                out_valid_q;

	assign cx = (cell_size_x == 16'd0) ? 16'd1 : cell_size_x;
	assign cy = (cell_size_y == 16'd0) ? 16'd1 : cell_size_y;

	always_comb begin
		if (state_q == B_MULX) begin
			prod = $signed({1'b0, cy}) * req_q.sx;
		end else if (state_q == B_MULY) begin
			prod = $signed({1'b0, cx}) * req_q.sy;
		end else begin
			prod = $signed({1'b0, cx}) * $signed({5'd0, cy});
		end
		pmag = prod[SLOPE_W+16] ? MAG_W'(-prod) : MAG_W'(prod);
	end

	always_comb begin
		m = mx_q;
		if (my_q > m) m = my_q;
		if (mz_q > m) m = mz_q;
		if (m[35])      s = 3'd6;
		else if (m[34]) s = 3'd5;
		else if (m[33]) s = 3'd4;
		else if (m[32]) s = 3'd3;
		else if (m[31]) s = 3'd2;
		else if (m[30]) s = 3'd1;
		else            s = 3'd0;
	end

	always_comb begin
		case (state_q)
			B_SQX:   sq_op = mx_q[29:0];
			B_SQY:   sq_op = my_q[29:0];
			default: sq_op = mz_q[29:0];
		endcase
		sq = sq_op * sq_op;
	end

	assign rrem   = {rem_q[ROOT_W-1:0], q_q[SQ_W-1 -: 2]};
	assign rtrial = {root_q, 2'b01};
	assign rt     = (root_q == '0) ? ROOT_W'(1) : root_q;

	always_comb begin
		case (ci_q)
			2'd0:    dm = mx_q;
			2'd1:    dm = my_q;
			default: dm = mz_q;
		endcase
		num   = {dm[29:0], 14'd0} + 45'(rt >> 1);
		drem2 = {drem_q[30:0], lo_q[14]};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) state_d = B_MULX;
			end
			B_MULX: state_d = B_MULY;
			B_MULY: state_d = B_MULC;
			B_MULC: state_d = B_MULZ;
			B_MULZ: state_d = B_NORM;
			B_NORM: state_d = B_SQX;
			B_SQX:  state_d = B_SQY;
			B_SQY:  state_d = B_SQZ;
			B_SQZ:  state_d = B_ROOT;
			B_ROOT: begin
				if (cnt_q == 5'd0) state_d = B_DIVS;
			end
			B_DIVS: state_d = B_DIV;
			B_DIV: begin
				if (cnt_q == 5'd0) state_d = (ci_q == 2'd2) ? B_DONE : B_DIVS;
			end
			B_DONE: begin
				if (!out_valid_q || pop) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		case (state_q)
			B_IDLE:  q_pop = !q_empty;
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				req_q <= q_req;
			end
			B_MULX: begin
				mx_q   <= pmag;
				negx_q <= prod[SLOPE_W+16];
			end
			B_MULY: begin
				my_q   <= pmag;
				negy_q <= prod[SLOPE_W+16];
			end
			B_MULC: begin
				mz_q <= pmag;
			end
			B_MULZ: begin
				mz_q <= (mz_q << 3) + (mz_q << 2);
			end
			B_NORM: begin
				mx_q <= mx_q >> s;
				my_q <= my_q >> s;
				mz_q <= mz_q >> s;
			end
			B_SQX: q_q <= SQ_W'(sq);
			B_SQY: q_q <= q_q + SQ_W'(sq);
			B_SQZ: begin
				q_q    <= q_q + SQ_W'(sq);
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= 5'd30;
				ci_q   <= 2'd0;
			end
			B_ROOT: begin
				q_q   <= q_q << 2;
				cnt_q <= cnt_q - 5'd1;
				if (rrem >= rtrial) begin
					rem_q  <= rrem - rtrial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rrem;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			B_DIVS: begin
				drem_q <= 32'(num[44:15]);
				lo_q   <= num[14:0];
				cnt_q  <= 5'd14;
				quo_q  <= '0;
			end
			B_DIV: begin
				lo_q  <= lo_q << 1;
				cnt_q <= cnt_q - 5'd1;
				if (drem2 >= 32'(rt)) begin
					drem_q <= drem2 - 32'(rt);
					quo_q  <= {quo_q[13:0], 1'b1};
				end else begin
					drem_q <= drem2;
					quo_q  <= {quo_q[13:0], 1'b0};
				end
				if (cnt_q == 5'd0) begin
					ci_q <= ci_q + 2'd1;
					if (ci_q == 2'd0) qx_q <= {quo_q[13:0], drem2 >= 32'(rt)};
					if (ci_q == 2'd1) qy_q <= {quo_q[13:0], drem2 >= 32'(rt)};
				end
			end
			B_DONE: begin
				if (!out_valid_q || pop) begin
					column        <= req_q.column;
					row           <= req_q.row;
					centre_height <= req_q.centre;
					last          <= req_q.last;
					normal_x      <= negx_q ? -16'(qx_q) : 16'(qx_q);
					normal_y      <= negy_q ? -16'(qy_q) : 16'(qy_q);
					normal_z      <= quo_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == B_DONE) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty = !out_valid_q;

`ifndef SYNTH
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> out_valid_q && $stable(normal_x) && $stable(column))
		else $error("waiting result overwritten");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == B_IDLE) else $error("queue popped while busy");
`endif

endmodule
